### rtl/core/abf_pkg.sv
// Shared types and constants of the advertising beacon filter.
package abf_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_COMPANY = 3'd0,
		REG_VERSION = 3'd1,
		REG_TYPE    = 3'd2,
		REG_NODE    = 3'd3,
		REG_AD_TYPE = 3'd4
	} cfg_idx_t;

	localparam int unsigned CFG_DATA_W = 16;

	// Reset values of the configuration registers
	localparam logic [15:0] RST_COMPANY = 16'hFFFF;
	localparam logic [7:0]  RST_VERSION = 8'h01;
	localparam logic [7:0]  RST_TYPE    = 8'h01;
	localparam logic [15:0] RST_NODE    = 16'h0001;
	localparam logic [7:0]  RST_AD_TYPE = 8'hFF;

	// Data byte positions inside a manufacturer structure
	localparam logic [3:0] DB_COMPANY_HI = 4'd0;
	localparam logic [3:0] DB_COMPANY_LO = 4'd1;
	localparam logic [3:0] DB_VERSION    = 4'd2;
	localparam logic [3:0] DB_TYPE       = 4'd3;
	localparam logic [3:0] DB_NODE_HI    = 4'd4;
	localparam logic [3:0] DB_NODE_LO    = 4'd5;
	localparam logic [3:0] DB_SEQ_HI     = 4'd6;
	localparam logic [3:0] DB_SEQ_LO     = 4'd7;
	localparam logic [3:0] DB_PAYLEN     = 4'd8;
	localparam logic [3:0] HDR_BYTES     = 4'd9;

	// Parser phase, one-hot
	typedef enum logic [3:0] {
		PH_LEN  = 4'b0001,
		PH_TYPE = 4'b0010,
		PH_DATA = 4'b0100,
		PH_STOP = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [15:0] company;
		logic [7:0]  version;
		logic [7:0]  mtype;
		logic [15:0] node;
		logic [7:0]  ad_type;
	} cfg_t;

	typedef struct packed {
		logic               hit;
		logic [15:0]        sequence_number;
		logic [7:0]         payload_length;
		logic signed [7:0]  signal_dbm;
		logic [31:0]        detection_count;
	} result_t;

endpackage

### rtl/core/abf_in_if.sv
// Input byte channel: valid/ready handshake with the payload byte fields.
interface abf_in_if;
	logic              valid;
	logic              ready;
	logic [7:0]        data_byte;
	logic              last_byte;
	logic signed [7:0] signal_strength;

	modport source (output valid, data_byte, last_byte, signal_strength, input ready);
	modport sink   (input valid, data_byte, last_byte, signal_strength, output ready);
endinterface

### rtl/core/abf_out_if.sv
// Result channel: valid/ready handshake with the beacon result fields.
interface abf_out_if;
	logic              valid;
	logic              ready;
	logic [15:0]       sequence_number;
	logic [7:0]        payload_length;
	logic signed [7:0] signal_dbm;
	logic [31:0]       detection_count;

	modport source (output valid, sequence_number, payload_length, signal_dbm,
		detection_count, input ready);
	modport sink   (input valid, sequence_number, payload_length, signal_dbm,
		detection_count, output ready);
endinterface

### rtl/core/adv_beacon_filter.sv
// Advertising beacon filter: input register, LTV parser, result register.
// A held byte is parsed once the result register is free; a hit then loads that register.
// Throughput: one byte per cycle while the result side takes results; a waiting result
// stops parsing, and the input channel stalls once the input register holds a byte.
// Reset: arst_n clears parse state, detection count and both valid flags, and loads the
// register reset values; no clearing pass.
module adv_beacon_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	abf_in_if.sink                          in_ch,
	abf_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  abf_pkg::cfg_idx_t               cfg_index,
	input  logic [abf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import abf_pkg::*;

	cfg_t              cfg;
	result_t           par_res;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic signed [7:0] sig_s1;
	logic              out_free;
	logic              proc_s1;
	logic              out_valid_q;
	logic [15:0]       seq_q;
	logic [7:0]        plen_q;
	logic signed [7:0] dbm_q;
	logic [31:0]       count_q;

	abf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Process the held byte only when the result register can take a result
	assign out_free    = !out_valid_q || out_ch.ready;
	assign proc_s1     = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (proc_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
			sig_s1  <= in_ch.signal_strength;
		end
	end

	abf_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (proc_s1),
		.data_byte       (byte_s1),
		.last_byte       (last_s1),
		.signal_strength (sig_s1),
		.cfg             (cfg),
		.res             (par_res)
	);

	// Result register: load on a hit, release after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc_s1 && par_res.hit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_s1 && par_res.hit) begin
			seq_q   <= par_res.sequence_number;
			plen_q  <= par_res.payload_length;
			dbm_q   <= par_res.signal_dbm;
			count_q <= par_res.detection_count;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.sequence_number = seq_q;
	assign out_ch.payload_length  = plen_q;
	assign out_ch.signal_dbm      = dbm_q;
	assign out_ch.detection_count = count_q;

	// A hit always lands in the result register with its count
	a_hit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(proc_s1 && par_res.hit) |=>
		(out_ch.valid && out_ch.detection_count == $past(par_res.detection_count)))
		else $error("parser hit not loaded into result register");

	// A pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |-> !(proc_s1 && par_res.hit))
		else $error("pending result overwritten");

	// An empty input register always takes a byte
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ch.ready)
		else $error("input register empty but not ready");

endmodule

### rtl/core/abf_cfg_regs.sv
// Configuration register file of the beacon filter.
module abf_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  abf_pkg::cfg_idx_t               cfg_index,
	input  logic [abf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output abf_pkg::cfg_t                   cfg
);
	import abf_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.company <= RST_COMPANY;
			cfg_q.version <= RST_VERSION;
			cfg_q.mtype   <= RST_TYPE;
			cfg_q.node    <= RST_NODE;
			cfg_q.ad_type <= RST_AD_TYPE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COMPANY: cfg_q.company <= cfg_wdata;
				REG_VERSION: cfg_q.version <= cfg_wdata[7:0];
				REG_TYPE:    cfg_q.mtype   <= cfg_wdata[7:0];
				REG_NODE:    cfg_q.node    <= cfg_wdata;
				REG_AD_TYPE: cfg_q.ad_type <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/abf_parser.sv
// Length-type-value walker with beacon header check and detection counter.
module abf_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic signed [7:0]   signal_strength,
	input  abf_pkg::cfg_t       cfg,
	output abf_pkg::result_t    res
);
	import abf_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  left_q, left_d;
	logic [3:0]  idx_q, idx_d;
	logic        manuf_q, manuf_d;
	logic        hok_q, hok_d;
	logic [15:0] seq_q, seq_d;
	logic [7:0]  plen_q, plen_d;
	logic [31:0] total_q, total_d;
	logic        hit;
	logic        test;
	logic [7:0]  want;
	logic [15:0] seq_res;
	logic [7:0]  plen_res;

	// Next parse state for the byte being processed
	always_comb begin
		phase_d  = phase_q;
		left_d   = left_q;
		idx_d    = idx_q;
		manuf_d  = manuf_q;
		hok_d    = hok_q;
		seq_d    = seq_q;
		plen_d   = plen_q;
		total_d  = total_q;
		hit      = 1'b0;
		test     = 1'b0;
		want     = '0;
		seq_res  = seq_q;
		plen_res = plen_q;
		if (fire) begin
			case (phase_q)
				PH_LEN: begin
					if (!last_byte) begin
						if (data_byte == 8'd0) begin
							phase_d = PH_STOP;
						end else begin
							left_d  = data_byte;
							phase_d = PH_TYPE;
						end
					end
				end
				PH_TYPE: begin
					manuf_d = (data_byte == cfg.ad_type);
					hok_d   = 1'b1;
					idx_d   = '0;
					left_d  = left_q - 8'd1;
					phase_d = (left_d == 8'd0) ? PH_LEN : PH_DATA;
				end
				PH_DATA: begin
					// Compare header bytes, capture sequence and length
					if (manuf_q && idx_q < HDR_BYTES) begin
						case (idx_q)
							DB_COMPANY_HI: begin test = 1'b1; want = cfg.company[15:8]; end
							DB_COMPANY_LO: begin test = 1'b1; want = cfg.company[7:0]; end
							DB_VERSION:    begin test = 1'b1; want = cfg.version; end
							DB_TYPE:       begin test = 1'b1; want = cfg.mtype; end
							DB_NODE_HI:    begin test = 1'b1; want = cfg.node[15:8]; end
							DB_NODE_LO:    begin test = 1'b1; want = cfg.node[7:0]; end
							DB_SEQ_HI:     seq_d  = {data_byte, seq_q[7:0]};
							DB_SEQ_LO:     seq_d  = {seq_q[15:8], data_byte};
							DB_PAYLEN:     plen_d = data_byte;
							default: ;
						endcase
						if (test && data_byte != want) begin
							hok_d = 1'b0;
						end
					end
					if (idx_q < HDR_BYTES) begin
						idx_d = idx_q + 4'd1;
					end
					left_d = left_q - 8'd1;
					// Structure complete: count a matching beacon
					if (left_d == 8'd0) begin
						if (manuf_q && hok_d && idx_d >= HDR_BYTES) begin
							hit     = 1'b1;
							total_d = total_q + 32'd1;
						end
						manuf_d = 1'b0;
						hok_d   = 1'b0;
						idx_d   = '0;
						phase_d = PH_LEN;
					end
				end
				PH_STOP: ;
				default: phase_d = PH_LEN;
			endcase
			// Take the result fields before the packet end clears them
			seq_res  = seq_d;
			plen_res = plen_d;
			// Packet end clears all per-structure state
			if (last_byte) begin
				phase_d = PH_LEN;
				left_d  = '0;
				idx_d   = '0;
				manuf_d = 1'b0;
				hok_d   = 1'b0;
				seq_d   = '0;
				plen_d  = '0;
			end
		end
	end

	// Hold parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			left_q  <= '0;
			idx_q   <= '0;
			manuf_q <= 1'b0;
			hok_q   <= 1'b0;
			seq_q   <= '0;
			plen_q  <= '0;
			total_q <= '0;
		end else begin
			phase_q <= phase_d;
			left_q  <= left_d;
			idx_q   <= idx_d;
			manuf_q <= manuf_d;
			hok_q   <= hok_d;
			seq_q   <= seq_d;
			plen_q  <= plen_d;
			total_q <= total_d;
		end
	end

	assign res.hit             = hit;
	assign res.sequence_number = seq_res;
	assign res.payload_length  = plen_res;
	assign res.signal_dbm      = signal_strength;
	assign res.detection_count = total_d;

endmodule

### dv/tb_adv_beacon_filter.sv
// Testbench for the advertising beacon filter: directed and random LTV packets, predictor and result checks.
module tb_adv_beacon_filter;
	import abf_pkg::*;

	typedef struct {
		logic [7:0]        data;
		logic              last;
		logic signed [7:0] rssi;
	} adv_byte_t;

	typedef struct {
		logic [15:0]       seq;
		logic [7:0]        paylen;
		logic signed [7:0] dbm;
		logic [31:0]       count;
	} beacon_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	abf_in_if  in_if ();
	abf_out_if out_if ();

	adv_beacon_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_if),
		.out_ch    (out_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Stimulus and expectation stores
	adv_byte_t  byte_queue[$];
	beacon_t    beacon_expect[$];
	logic [7:0] pkt_bytes[$];
	int         bytes_queued;
	int         bytes_sent;
	int         mismatches;

	// Mirror of the configuration registers
	cfg_t       cfg_now;

	// Parser state of the predictor
	phase_t      parse_ph;
	logic [7:0]  bytes_owed;
	logic [3:0]  data_idx;
	logic        is_manuf;
	logic        hdr_match;
	logic [15:0] seq_acc;
	logic [7:0]  paylen_acc;
	logic [31:0] match_total;

	// Sender and receiver pacing
	int          burst_left;
	int          gap_left;
	int          stall_run;
	logic        ready_lvl;

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (mismatches < 50)
			$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic clear_structure();
		parse_ph   = PH_LEN;
		bytes_owed = '0;
		data_idx   = '0;
		is_manuf   = 1'b0;
		hdr_match  = 1'b0;
		seq_acc    = '0;
		paylen_acc = '0;
	endtask

	// Advance the parser by one transferred byte; queue a beacon when one completes
	task automatic track_byte(input adv_byte_t b);
		beacon_t hit;
		case (parse_ph)
			PH_LEN: begin
				if (!b.last) begin
					if (b.data == 8'd0) begin
						parse_ph = PH_STOP;
					end else begin
						bytes_owed = b.data;
						parse_ph   = PH_TYPE;
					end
				end
			end
			PH_TYPE: begin
				is_manuf   = (b.data == cfg_now.ad_type);
				hdr_match  = 1'b1;
				data_idx   = '0;
				bytes_owed = bytes_owed - 8'd1;
				parse_ph   = (bytes_owed == 8'd0) ? PH_LEN : PH_DATA;
			end
			PH_DATA: begin
				if (is_manuf && data_idx < HDR_BYTES) begin
					case (data_idx)
						DB_COMPANY_HI: if (b.data != cfg_now.company[15:8]) hdr_match = 1'b0;
						DB_COMPANY_LO: if (b.data != cfg_now.company[7:0]) hdr_match = 1'b0;
						DB_VERSION:    if (b.data != cfg_now.version) hdr_match = 1'b0;
						DB_TYPE:       if (b.data != cfg_now.mtype) hdr_match = 1'b0;
						DB_NODE_HI:    if (b.data != cfg_now.node[15:8]) hdr_match = 1'b0;
						DB_NODE_LO:    if (b.data != cfg_now.node[7:0]) hdr_match = 1'b0;
						DB_SEQ_HI:     seq_acc[15:8] = b.data;
						DB_SEQ_LO:     seq_acc[7:0] = b.data;
						DB_PAYLEN:     paylen_acc = b.data;
						default: ;
					endcase
				end
				if (data_idx < HDR_BYTES)
					data_idx = data_idx + 4'd1;
				bytes_owed = bytes_owed - 8'd1;
				if (bytes_owed == 8'd0) begin
					if (is_manuf && hdr_match && data_idx >= HDR_BYTES) begin
						match_total = match_total + 32'd1;
						hit.seq     = seq_acc;
						hit.paylen  = paylen_acc;
						hit.dbm     = b.rssi;
						hit.count   = match_total;
						beacon_expect.push_back(hit);
					end
					is_manuf  = 1'b0;
					hdr_match = 1'b0;
					data_idx  = '0;
					parse_ph  = PH_LEN;
				end
			end
			default: ;
		endcase
		if (b.last)
			clear_structure();
	endtask

	// Append a manufacturer structure with the configured header; corrupt one header byte if asked
	task automatic add_beacon(input bit corrupt, input int extra);
		logic [7:0] hdr[9];
		int         k;
		hdr[0] = cfg_now.company[15:8];
		hdr[1] = cfg_now.company[7:0];
		hdr[2] = cfg_now.version;
		hdr[3] = cfg_now.mtype;
		hdr[4] = cfg_now.node[15:8];
		hdr[5] = cfg_now.node[7:0];
		hdr[6] = 8'($urandom);
		hdr[7] = 8'($urandom);
		hdr[8] = 8'($urandom);
		if (corrupt) begin
			k = $urandom_range(0, 5);
			hdr[k] = hdr[k] ^ 8'($urandom_range(1, 255));
		end
		pkt_bytes.push_back(8'(10 + extra));
		pkt_bytes.push_back(cfg_now.ad_type);
		foreach (hdr[i])
			pkt_bytes.push_back(hdr[i]);
		repeat (extra)
			pkt_bytes.push_back(8'($urandom));
	endtask

	// Append a structure of the given AD type with random data
	task automatic add_field(input logic [7:0] ad, input int ndata);
		pkt_bytes.push_back(8'(ndata + 1));
		pkt_bytes.push_back(ad);
		repeat (ndata)
			pkt_bytes.push_back(8'($urandom));
	endtask

	// Move the assembled packet to the send queue, optionally truncated, marking its final byte
	task automatic send_packet(input int keep, input bit fix_rssi, input logic signed [7:0] rssi);
		adv_byte_t b;
		int        n;
		n = (keep > 0 && keep < pkt_bytes.size()) ? keep : pkt_bytes.size();
		for (int i = 0; i < n; i++) begin
			b.data = pkt_bytes[i];
			b.last = (i == n - 1);
			b.rssi = fix_rssi ? rssi : 8'($urandom);
			byte_queue.push_back(b);
		end
		bytes_queued += n;
		pkt_bytes.delete();
	endtask

	// Build one random packet: mostly well-formed structures, some broken or noise
	task automatic random_packet();
		int         r;
		int         nfield;
		int         keep;
		int         extra;
		logic [7:0] other;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			repeat ($urandom_range(1, 12))
				pkt_bytes.push_back(8'($urandom));
			send_packet(0, 1'b0, 8'sd0);
		end else begin
			nfield = $urandom_range(1, 3);
			repeat (nfield) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					if ($urandom_range(0, 99) == 0)
						extra = $urandom_range(5, 245);
					else if ($urandom_range(0, 99) < 15)
						extra = $urandom_range(1, 4);
					else
						extra = 0;
					add_beacon(1'b0, extra);
				end else if (r < 65) begin
					add_beacon(1'b1, $urandom_range(0, 2));
				end else if (r < 75) begin
					add_field(cfg_now.ad_type, $urandom_range(0, 8));
				end else if (r < 92) begin
					do
						other = 8'($urandom);
					while (other == cfg_now.ad_type);
					add_field(other, $urandom_range(0, 12));
				end else begin
					// zero length stops parsing; trailing bytes are skipped
					pkt_bytes.push_back(8'd0);
					repeat ($urandom_range(0, 3))
						pkt_bytes.push_back(8'($urandom));
				end
			end
			if ($urandom_range(0, 99) < 8)
				pkt_bytes.push_back(8'($urandom_range(1, 255)));
			keep = 0;
			if ($urandom_range(0, 99) < 10 && pkt_bytes.size() > 1)
				keep = $urandom_range(1, pkt_bytes.size() - 1);
			send_packet(keep, 1'b0, 8'sd0);
		end
	endtask

	// Wait until every byte is transferred and every beacon has arrived, or the limit runs out, then settle
	task automatic drain(input int limit);
		int n;
		n = 0;
		while ((bytes_sent != bytes_queued || beacon_expect.size() != 0) && n < limit) begin
			@(posedge clk);
			n++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
	endtask

	// Load a full register set in back-to-back writes; junk in the unused upper bits
	task automatic load_settings(input cfg_t s);
		cfg_now = s;
		write_reg(REG_COMPANY, s.company);
		write_reg(REG_VERSION, {8'($urandom), s.version});
		write_reg(REG_TYPE, {8'($urandom), s.mtype});
		write_reg(REG_NODE, s.node);
		write_reg(REG_AD_TYPE, {8'($urandom), s.ad_type});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver: present queued bytes in bursts, predict each transfer
	always @(posedge clk) begin
		adv_byte_t cur;
		logic      drive;
		if (!arst_n) begin
			in_if.valid <= 1'b0;
		end else begin
			if (in_if.valid && in_if.ready) begin
				track_byte(cur);
				bytes_sent++;
			end
			drive = 1'b0;
			if (in_if.valid && !in_if.ready) begin
				drive = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (byte_queue.size() > 0) begin
				cur = byte_queue.pop_front();
				in_if.data_byte       <= cur.data;
				in_if.last_byte       <= cur.last;
				in_if.signal_strength <= cur.rssi;
				drive = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 16);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			in_if.valid <= drive;
		end
	end

	// Receiver: stall in runs, with long stretches of steady ready
	always @(posedge clk) begin
		int r;
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			if (stall_run > 0) begin
				stall_run--;
			end else begin
				r = $urandom_range(0, 9);
				if (r < 2) begin
					ready_lvl = 1'b1;
					stall_run = $urandom_range(20, 60);
				end else begin
					ready_lvl = (r < 7);
					stall_run = $urandom_range(0, 7);
				end
			end
			out_if.ready <= ready_lvl;
		end
	end

	// Monitor: compare each result transfer with the oldest expected beacon
	always @(posedge clk) begin
		beacon_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (beacon_expect.size() == 0) begin
				report_mismatch($sformatf("unexpected result seq %04h count %0d",
					out_if.sequence_number, out_if.detection_count));
			end else begin
				want = beacon_expect.pop_front();
				if (out_if.sequence_number !== want.seq)
					report_mismatch($sformatf("sequence_number %04h, want %04h",
						out_if.sequence_number, want.seq));
				if (out_if.payload_length !== want.paylen)
					report_mismatch($sformatf("payload_length %02h, want %02h",
						out_if.payload_length, want.paylen));
				if (out_if.signal_dbm !== want.dbm)
					report_mismatch($sformatf("signal_dbm %0d, want %0d",
						out_if.signal_dbm, want.dbm));
				if (out_if.detection_count !== want.count)
					report_mismatch($sformatf("detection_count %0d, want %0d",
						out_if.detection_count, want.count));
			end
		end
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Reset, directed packets, then random phases under several register settings
	initial begin
		cfg_t s;
		int   target;
		clk                   = 1'b0;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = REG_COMPANY;
		cfg_wdata             = '0;
		in_if.valid           = 1'b0;
		in_if.data_byte       = '0;
		in_if.last_byte       = 1'b0;
		in_if.signal_strength = '0;
		out_if.ready          = 1'b0;
		bytes_queued          = 0;
		bytes_sent            = 0;
		mismatches            = 0;
		burst_left            = 1;
		gap_left              = 0;
		stall_run             = 0;
		ready_lvl             = 1'b1;
		match_total           = '0;
		cfg_now               = '{RST_COMPANY, RST_VERSION, RST_TYPE, RST_NODE, RST_AD_TYPE};
		clear_structure();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// matching beacon ending the packet, weakest signal
		add_beacon(1'b0, 0);
		send_packet(0, 1'b1, -8'sd128);
		// length byte as the final byte
		pkt_bytes.push_back(8'd5);
		send_packet(0, 1'b1, 8'sd127);
		// zero length stops parsing until packet end
		pkt_bytes.push_back(8'd0);
		pkt_bytes.push_back(8'hFF);
		send_packet(0, 1'b1, 8'sd127);
		// manufacturer structure one byte short of a header
		add_field(cfg_now.ad_type, 8);
		send_packet(0, 1'b1, -8'sd1);

		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				drain(20000);
				case (ph)
					1: s = '{16'h0000, 8'h00, 8'h00, 16'h0000, 8'h00};
					2: s = '{16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF};
					default: s = '{16'($urandom), 8'($urandom), 8'($urandom),
						16'($urandom), 8'($urandom)};
				endcase
				load_settings(s);
			end
			target = bytes_queued + 240;
			while (bytes_queued < target)
				random_packet();
		end

		drain(20000);
		if (beacon_expect.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived", beacon_expect.size()));
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/core/abf_pkg.sv
rtl/core/abf_in_if.sv
rtl/core/abf_out_if.sv
rtl/core/abf_cfg_regs.sv
rtl/core/abf_parser.sv
rtl/core/adv_beacon_filter.sv
dv/tb_adv_beacon_filter.sv
